// File: sv/mpct_pkg.sv
// ----------------------------------------------------------------------------
// Mouse packet cursor tracker package
// Shared types, constants and arithmetic helpers for the cursor tracker.
// ----------------------------------------------------------------------------
package mpct_pkg;

  localparam int unsigned CoordW  = 10;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned ButtonW = 3;
  localparam int unsigned CfgIdxW = 2;
  // Wide enough for a coordinate plus or minus a nine-bit delta, with sign.
  localparam int unsigned SumW    = CoordW + 2;
  localparam int unsigned DeltaW  = 9;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [CoordW-1:0] ResetXLimit = CoordW'(800 - 16);
  localparam logic [CoordW-1:0] ResetYLimit = CoordW'(600 - 24);
  localparam logic [CoordW-1:0] ResetPosX   = CoordW'(800 / 2);
  localparam logic [CoordW-1:0] ResetPosY   = CoordW'(600 / 2);

  // Header bit positions.
  localparam int unsigned HdrXSignBit = 4;
  localparam int unsigned HdrYSignBit = 5;
  localparam int unsigned HdrXOvfBit  = 6;
  localparam int unsigned HdrYOvfBit  = 7;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgXLimit = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgYLimit = CfgIdxW'(1);

  // Slot of the next byte within a packet.
  typedef enum logic [1:0] {
    SlotHeader = 2'd0,
    SlotXDelta = 2'd1,
    SlotYDelta = 2'd2
  } slot_e;

  // One complete packet as passed from the front end to the back end.
  typedef struct packed {
    logic [ByteW-1:0] header;
    logic [ByteW-1:0] x_delta;
    logic [ByteW-1:0] y_delta;
  } packet_t;

  // Queue status seen by the input stall logic and the back end.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Standard nine-bit delta: the sign bit sits on top of the byte.
  function automatic logic [DeltaW-1:0] delta_nine(input logic [ByteW-1:0] b,
                                                   input logic neg);
    delta_nine = {neg, b};
  endfunction

  // Signed byte halved, truncated toward zero, as a nine-bit value.
  function automatic logic [DeltaW-1:0] delta_half(input logic [ByteW-1:0] b);
    logic [DeltaW-1:0] biased;
    biased     = {b[ByteW-1], b} + {{(DeltaW-1){1'b0}}, b[ByteW-1]};
    delta_half = {biased[DeltaW-1], biased[DeltaW-1:1]};
  endfunction

  // Clamp a signed sum to the range 0 through lim.
  function automatic logic [CoordW-1:0] clamp_coord(input logic [SumW-1:0] v,
                                                    input logic [CoordW-1:0] lim);
    if (v[SumW-1] || (v == '0)) begin
      clamp_coord = '0;
    end else if (v[SumW-2:0] >= {1'b0, lim}) begin
      clamp_coord = lim;
    end else begin
      clamp_coord = v[CoordW-1:0];
    end
  endfunction

endpackage

// File: sv/mouse_packet_cursor_tracker.sv
// ----------------------------------------------------------------------------
// Mouse packet cursor tracker
// Gathers three-byte pointing-device packets and tracks a clamped cursor.
// ----------------------------------------------------------------------------
// Usage. Received device bytes arrive one request at a time on the input
// channel (in_valid_i, in_stall_o, rx_byte_i). Every third byte completes a
// packet, and one request then leaves on the output channel (out_valid_o,
// out_stall_i) carrying the cursor position and the three button bits.
// The first two bytes of a packet produce nothing on the output.
// Throughput is one byte per cycle while in_stall_o is low. A completed
// packet is registered in the queue, then in the output register.
// The gatherer hands completed packets to a two-entry queue, and the
// position update drains that queue into a single output register. While
// the receiver stalls, the output register holds its request and the queue
// fills; the input stalls only once the queue is full, so header and
// X delta bytes keep flowing meanwhile. Reset returns the cursor to 400,
// 300, the limits to 784 and 576, and the packet byte count to the header
// slot. The user writes the limits via the configuration port (index 0 for
// X, 1 for Y) only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module mouse_packet_cursor_tracker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration writes.
  input  logic                          cfg_we_i,
  input  logic [mpct_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mpct_pkg::CoordW-1:0]   cfg_data_i,
  // Incoming bytes.
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [mpct_pkg::ByteW-1:0]    rx_byte_i,
  // Outgoing cursor updates.
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mpct_pkg::CoordW-1:0]   cursor_x_o,
  output logic [mpct_pkg::CoordW-1:0]   cursor_y_o,
  output logic [mpct_pkg::ButtonW-1:0]  buttons_o
);
  import mpct_pkg::*;

  logic          accept;
  logic          push;
  logic          pop;
  packet_t       pkt_in;
  packet_t       pkt_out;
  queue_status_t q_status;

  // The input is held off only when the queue has no room, which covers the
  // worst case of the byte that completes a packet.
  assign in_stall_o = q_status.full;
  assign accept     = in_valid_i && !in_stall_o;

  mpct_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .push_o    (push),
    .pkt_o     (pkt_in)
  );

  mpct_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pkt_i    (pkt_in),
    .pop_i    (pop),
    .pkt_o    (pkt_out),
    .status_o (q_status)
  );

  mpct_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .q_status_i  (q_status),
    .pkt_i       (pkt_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cursor_x_o  (cursor_x_o),
    .cursor_y_o  (cursor_y_o),
    .buttons_o   (buttons_o)
  );

  // A completed packet is never pushed into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && q_status.full))
    else $error("packet pushed into a full queue");

  // The position update never takes from an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && q_status.empty))
    else $error("packet popped from an empty queue");

  // A waiting result only goes away once the receiver has taken it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");

  // A queued packet while the output is free is drained in that cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!q_status.empty && !out_valid_o) |-> pop)
    else $error("queued packet left waiting behind an empty output");

endmodule

// File: sv/mpct_front.sv
// ----------------------------------------------------------------------------
// Packet gatherer
// Counts received bytes into header, X delta and Y delta slots and hands
// each completed packet to the queue.
// ----------------------------------------------------------------------------
module mpct_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [mpct_pkg::ByteW-1:0]    rx_byte_i,
  output logic                          push_o,
  output mpct_pkg::packet_t             pkt_o
);
  import mpct_pkg::*;

  slot_e            slot_q, slot_d;
  logic [ByteW-1:0] header_q, header_d;
  logic [ByteW-1:0] x_delta_q, x_delta_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q    <= SlotHeader;
      header_q  <= '0;
      x_delta_q <= '0;
    end else begin
      slot_q    <= slot_d;
      header_q  <= header_d;
      x_delta_q <= x_delta_d;
    end
  end

  always_comb begin
    slot_d    = slot_q;
    header_d  = header_q;
    x_delta_d = x_delta_q;
    push_o    = 1'b0;
    if (accept_i) begin
      unique case (slot_q)
        SlotHeader: begin
          header_d = rx_byte_i;
          slot_d   = SlotXDelta;
        end
        SlotXDelta: begin
          x_delta_d = rx_byte_i;
          slot_d    = SlotYDelta;
        end
        SlotYDelta: begin
          push_o = 1'b1;
          slot_d = SlotHeader;
        end
        default: begin
          // An unused slot code behaves as the last byte of a packet.
          push_o = 1'b1;
          slot_d = SlotHeader;
        end
      endcase
    end
  end

  assign pkt_o.header  = header_q;
  assign pkt_o.x_delta = x_delta_q;
  assign pkt_o.y_delta = rx_byte_i;

endmodule

// File: sv/mpct_queue.sv
// ----------------------------------------------------------------------------
// Packet queue
// Small register queue that lets the gatherer and the position update
// stall independently of one another.
// ----------------------------------------------------------------------------
module mpct_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  mpct_pkg::packet_t       pkt_i,
  input  logic                    pop_i,
  output mpct_pkg::packet_t       pkt_o,
  output mpct_pkg::queue_status_t status_o
);
  import mpct_pkg::*;

  packet_t              mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] count_q, count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= pkt_i;
    end
  end

  function automatic logic [QueuePtrW-1:0] next_ptr(input logic [QueuePtrW-1:0] p);
    if (p == QueuePtrW'(QueueDepth - 1)) begin
      next_ptr = '0;
    end else begin
      next_ptr = p + QueuePtrW'(1);
    end
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + QueueCntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QueueCntW'(1);
    end
  end

  assign pkt_o          = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == QueueCntW'(QueueDepth));
  assign status_o.empty = (count_q == '0);

endmodule

// File: sv/mpct_back.sv
// ----------------------------------------------------------------------------
// Cursor position update
// Applies one packet's deltas to the cursor, clamps to the limits and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module mpct_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mpct_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mpct_pkg::CoordW-1:0]   cfg_data_i,
  input  mpct_pkg::queue_status_t       q_status_i,
  input  mpct_pkg::packet_t             pkt_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mpct_pkg::CoordW-1:0]   cursor_x_o,
  output logic [mpct_pkg::CoordW-1:0]   cursor_y_o,
  output logic [mpct_pkg::ButtonW-1:0]  buttons_o
);
  import mpct_pkg::*;

  logic [CoordW-1:0]  x_limit_q, y_limit_q;
  logic [CoordW-1:0]  pos_x_q, pos_x_d;
  logic [CoordW-1:0]  pos_y_q, pos_y_d;
  logic               out_valid_q, out_valid_d;
  logic [ButtonW-1:0] buttons_q;
  logic [DeltaW-1:0]  dx, dy;
  logic [SumW-1:0]    sum_x, sum_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_limit_q <= ResetXLimit;
      y_limit_q <= ResetYLimit;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgXLimit) begin
        x_limit_q <= cfg_data_i;
      end else if (cfg_idx_i == CfgYLimit) begin
        y_limit_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    if (pkt_i.header[HdrXOvfBit]) begin
      dx = delta_half(pkt_i.x_delta);
    end else begin
      dx = delta_nine(pkt_i.x_delta, pkt_i.header[HdrXSignBit]);
    end
    if (pkt_i.header[HdrYOvfBit]) begin
      dy = delta_half(pkt_i.y_delta);
    end else begin
      dy = delta_nine(pkt_i.y_delta, pkt_i.header[HdrYSignBit]);
    end
    sum_x = {2'b00, pos_x_q} + {{(SumW-DeltaW){dx[DeltaW-1]}}, dx};
    sum_y = {2'b00, pos_y_q} - {{(SumW-DeltaW){dy[DeltaW-1]}}, dy};
  end

  assign pop_o = !q_status_i.empty && (!out_valid_q || !out_stall_i);

  always_comb begin
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    out_valid_d = out_valid_q;
    if (pop_o) begin
      pos_x_d     = clamp_coord(sum_x, x_limit_q);
      pos_y_d     = clamp_coord(sum_y, y_limit_q);
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q     <= ResetPosX;
      pos_y_q     <= ResetPosY;
      out_valid_q <= 1'b0;
    end else begin
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      buttons_q <= pkt_i.header[ButtonW-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign cursor_x_o  = pos_x_q;
  assign cursor_y_o  = pos_y_q;
  assign buttons_o   = buttons_q;

endmodule

// File: sim/mpct_checker.sv
// ----------------------------------------------------------------------------
// Cursor tracker checker
// Watches the byte and cursor channels, predicts every cursor update from
// the accepted bytes and compares each update field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module mpct_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mpct_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mpct_pkg::CoordW-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [mpct_pkg::ByteW-1:0]    rx_byte_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [mpct_pkg::CoordW-1:0]   cursor_x_i,
  input  logic [mpct_pkg::CoordW-1:0]   cursor_y_i,
  input  logic [mpct_pkg::ButtonW-1:0]  buttons_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  typedef struct packed {
    logic [mpct_pkg::CoordW-1:0]  x;
    logic [mpct_pkg::CoordW-1:0]  y;
    logic [mpct_pkg::ButtonW-1:0] buttons;
  } cursor_t;

  cursor_t                      expected_cursor_q[$];
  mpct_pkg::slot_e              slot;
  logic [mpct_pkg::ByteW-1:0]   header_q;
  logic [mpct_pkg::ByteW-1:0]   x_delta_q;
  logic [mpct_pkg::CoordW-1:0]  pos_x;
  logic [mpct_pkg::CoordW-1:0]  pos_y;
  logic [mpct_pkg::CoordW-1:0]  x_limit;
  logic [mpct_pkg::CoordW-1:0]  y_limit;
  int                           fails;

  // Movement for one axis: a nine-bit delta normally, or half the signed
  // byte (truncated toward zero) when the overflow bit is set.
  function automatic int axis_move(input logic [mpct_pkg::ByteW-1:0] b,
                                   input logic sign, input logic ovf);
    int v;
    v = int'($signed(b));
    if (ovf) begin
      return v / 2;
    end
    return sign ? int'(b) - 256 : int'(b);
  endfunction

  function automatic logic [mpct_pkg::CoordW-1:0] clamp_to_limit(
      input int v, input logic [mpct_pkg::CoordW-1:0] lim);
    if (v <= 0) begin
      return '0;
    end
    if (v >= int'(lim)) begin
      return lim;
    end
    return v[mpct_pkg::CoordW-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cursor_t want;
    int      nx;
    int      ny;
    if (!rst_ni) begin
      expected_cursor_q.delete();
      slot         = mpct_pkg::SlotHeader;
      header_q     = '0;
      x_delta_q    = '0;
      pos_x        = mpct_pkg::ResetPosX;
      pos_y        = mpct_pkg::ResetPosY;
      x_limit      = mpct_pkg::ResetXLimit;
      y_limit      = mpct_pkg::ResetYLimit;
      fails        = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == mpct_pkg::CfgXLimit) begin
          x_limit = cfg_data_i;
        end else if (cfg_idx_i == mpct_pkg::CfgYLimit) begin
          y_limit = cfg_data_i;
        end
      end

      if (out_valid_i && !out_stall_i) begin
        if (expected_cursor_q.size() == 0) begin
          $display("%0t: unexpected cursor update, expected none, got x %0d y %0d buttons %0d",
                   $time, cursor_x_i, cursor_y_i, buttons_i);
          fails++;
        end else begin
          want = expected_cursor_q.pop_front();
          if (cursor_x_i !== want.x) begin
            $display("%0t: cursor_x expected %0d, got %0d", $time, want.x, cursor_x_i);
            fails++;
          end
          if (cursor_y_i !== want.y) begin
            $display("%0t: cursor_y expected %0d, got %0d", $time, want.y, cursor_y_i);
            fails++;
          end
          if (buttons_i !== want.buttons) begin
            $display("%0t: buttons expected %0d, got %0d", $time, want.buttons, buttons_i);
            fails++;
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        case (slot)
          mpct_pkg::SlotHeader: begin
            header_q = rx_byte_i;
            slot     = mpct_pkg::SlotXDelta;
          end
          mpct_pkg::SlotXDelta: begin
            x_delta_q = rx_byte_i;
            slot      = mpct_pkg::SlotYDelta;
          end
          default: begin
            nx = int'(pos_x) + axis_move(x_delta_q, header_q[mpct_pkg::HdrXSignBit],
                                         header_q[mpct_pkg::HdrXOvfBit]);
            ny = int'(pos_y) - axis_move(rx_byte_i, header_q[mpct_pkg::HdrYSignBit],
                                         header_q[mpct_pkg::HdrYOvfBit]);
            pos_x = clamp_to_limit(nx, x_limit);
            pos_y = clamp_to_limit(ny, y_limit);
            expected_cursor_q.push_back('{pos_x, pos_y,
                                          header_q[mpct_pkg::ButtonW-1:0]});
            slot = mpct_pkg::SlotHeader;
          end
        endcase
      end

      pending_o    <= expected_cursor_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// Cursor tracker testbench
// Feeds device bytes into the tracker under changing limits and idling,
// while a checker beside the block predicts and compares cursor updates.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          cfg_we_i    = 1'b0;
  logic [mpct_pkg::CfgIdxW-1:0]  cfg_idx_i   = mpct_pkg::CfgXLimit;
  logic [mpct_pkg::CoordW-1:0]   cfg_data_i  = '0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  logic [mpct_pkg::ByteW-1:0]    rx_byte_i   = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [mpct_pkg::CoordW-1:0]   cursor_x_o;
  logic [mpct_pkg::CoordW-1:0]   cursor_y_o;
  logic [mpct_pkg::ButtonW-1:0]  buttons_o;

  int fail_count;
  int pending;

  // Idling odds, in percent, for the byte sender and the cursor receiver.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // Set while the sender must keep offering bytes without any gap.
  logic no_gaps = 1'b0;
  // Each increment asks the receiver for one long hold-off.
  int hold_token = 0;
  int hold_seen  = 0;
  int hold_left  = 0;

  always #5 clk_i = ~clk_i;

  mouse_packet_cursor_tracker u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cursor_x_o  (cursor_x_o),
    .cursor_y_o  (cursor_y_o),
    .buttons_o   (buttons_o)
  );

  mpct_checker u_cursor_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cursor_x_i   (cursor_x_o),
    .cursor_y_i   (cursor_y_o),
    .buttons_i    (buttons_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // The receiver stalls at random, except during a long hold-off, which it
  // counts out itself. A hold-off lasts long enough for the two-entry packet
  // queue and the output register to fill, so that the input side stalls.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_token != hold_seen) begin
      hold_seen   <= hold_token;
      hold_left   <= 80;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Offers one byte and returns at the edge that accepts it. Valid is only
  // lowered at the start of a gap, never in the step where it rises again.
  // Every cycle of a gap is idle with the sender's odds, so that the share
  // of idle cycles matches those odds.
  task automatic send_byte(input logic [mpct_pkg::ByteW-1:0] b);
    if (!no_gaps && ($urandom_range(99) < send_idle_pct)) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_packet(input logic [mpct_pkg::ByteW-1:0] hdr,
                             input logic [mpct_pkg::ByteW-1:0] xd,
                             input logic [mpct_pkg::ByteW-1:0] yd);
    send_byte(hdr);
    send_byte(xd);
    send_byte(yd);
  endtask

  // Stops sending and waits until every predicted cursor update has been
  // seen. The pending count from the checker is registered, hence the
  // edge before the first look. An extra wait then lets a packet that is
  // still passing through the queue settle before the limits change.
  task automatic wait_for_cursor_updates();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (3) @(posedge clk_i);
  endtask

  // Writes both limits on consecutive edges. The write enable is low again
  // at the last edge that the task waits for, so it never falls and rises together.
  task automatic write_limits(input logic [mpct_pkg::CoordW-1:0] x_lim,
                              input logic [mpct_pkg::CoordW-1:0] y_lim);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= mpct_pkg::CfgXLimit;
    cfg_data_i <= x_lim;
    @(posedge clk_i);
    cfg_idx_i  <= mpct_pkg::CfgYLimit;
    cfg_data_i <= y_lim;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  // Delta bytes: half of them anywhere in the range, the rest small moves
  // either way, so that the cursor wanders rather than sitting on a limit.
  function automatic logic [mpct_pkg::ByteW-1:0] pick_delta();
    case ($urandom_range(3))
      2:       return mpct_pkg::ByteW'($urandom_range(0, 15));
      3:       return mpct_pkg::ByteW'($urandom_range(240, 255));
      default: return mpct_pkg::ByteW'($urandom_range(255));
    endcase
  endfunction

  initial begin
    logic [mpct_pkg::ByteW-1:0]  hdr;
    logic [mpct_pkg::ByteW-1:0]  xd;
    logic [mpct_pkg::ByteW-1:0]  yd;
    logic [mpct_pkg::CoordW-1:0] x_lim;
    logic [mpct_pkg::CoordW-1:0] y_lim;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed packets at the reset limits, starting from the centre.
    // No movement at all.
    send_packet(8'h00, 8'h00, 8'h00);
    // All three buttons and the largest positive X delta.
    send_packet(8'h07, 8'hFF, 8'h00);
    // X sign with a zero byte gives the most negative nine-bit delta.
    send_packet(8'h11, 8'h00, 8'h00);
    // Y sign with a zero byte: the cursor moves down by 256.
    send_packet(8'h22, 8'h00, 8'h00);
    // X overflow with minus one: halving truncates toward zero, so no move.
    send_packet(8'h40, 8'hFF, 8'h00);
    // X overflow with the most negative byte.
    send_packet(8'h44, 8'h80, 8'h00);
    // Y overflow with a negative byte, pushing Y past its limit.
    send_packet(8'h80, 8'h00, 8'h81);
    // Both overflow bits with the sign bits set, which are then ignored.
    send_packet(8'hF3, 8'h7F, 8'h7F);
    // Large moves towards zero on both axes.
    send_packet(8'h10, 8'h00, 8'hFF);
    wait_for_cursor_updates();

    // Random phases. The first two have a lazy receiver, the next two a
    // lazy sender, the last two no idling at all. The limits change at each
    // phase boundary, covering both extremes and a limit written below the
    // current position, which must bite at the next completed packet.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase / 2)
        0: begin
          send_idle_pct = 10;
          recv_idle_pct <= 55;
        end
        1: begin
          send_idle_pct = 55;
          recv_idle_pct <= 10;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase

      case (phase)
        1: begin
          x_lim = '0;
          y_lim = '0;
        end
        2: begin
          x_lim = '1;
          y_lim = '1;
        end
        3: begin
          x_lim = 10'd37;
          y_lim = 10'd21;
        end
        4: begin
          x_lim = mpct_pkg::CoordW'($urandom_range(1023));
          y_lim = mpct_pkg::CoordW'($urandom_range(1023));
        end
        5: begin
          x_lim = 10'd600;
          y_lim = 10'd1;
        end
        default: begin
          x_lim = mpct_pkg::ResetXLimit;
          y_lim = mpct_pkg::ResetYLimit;
        end
      endcase
      if (phase > 0) begin
        write_limits(x_lim, y_lim);
      end

      for (int n = 0; n < 85; n++) begin
        // Long receiver hold-off while the sender keeps pushing bytes.
        if (phase == 1 && n == 30) begin
          hold_token <= hold_token + 1;
          no_gaps = 1'b1;
        end
        if (phase == 1 && n == 50) begin
          no_gaps = 1'b0;
        end
        // A sender pause that lets the whole pipeline empty mid-phase.
        if (phase == 1 && n == 60) begin
          wait_for_cursor_updates();
        end

        hdr = mpct_pkg::ByteW'($urandom_range(255));
        xd  = pick_delta();
        yd  = pick_delta();
        // Most packets look like those of a real device: sign bits match
        // the delta bytes and overflow is rare. The rest are raw noise.
        if ($urandom_range(9) < 7) begin
          hdr[mpct_pkg::HdrXSignBit] = xd[mpct_pkg::ByteW-1];
          hdr[mpct_pkg::HdrYSignBit] = yd[mpct_pkg::ByteW-1];
          if ($urandom_range(9) != 0) begin
            hdr[mpct_pkg::HdrXOvfBit] = 1'b0;
            hdr[mpct_pkg::HdrYOvfBit] = 1'b0;
          end
        end
        send_packet(hdr, xd, yd);
      end

      // Leave a packet half gathered across a limit change once, so that
      // the byte count runs out of step with the phase boundaries.
      if (phase == 3) begin
        send_byte(mpct_pkg::ByteW'($urandom_range(255)));
      end
      wait_for_cursor_updates();
    end

    repeat (5) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: sim.f
sv/mpct_pkg.sv
sv/mpct_front.sv
sv/mpct_queue.sv
sv/mpct_back.sv
sv/mouse_packet_cursor_tracker.sv
sim/mpct_checker.sv
sim/tb_top.sv
